/* hw/rtl/ipv6_prefix_to_mac_table_macros.svh */
// ----------------------------------------------------------------------------
// ipv6_prefix_to_mac_table_macros.svh
// Assertion shorthands used by the prefix table controller.
// ----------------------------------------------------------------------------
`ifndef IPV6_PREFIX_TO_MAC_TABLE_MACROS_SVH
`define IPV6_PREFIX_TO_MAC_TABLE_MACROS_SVH

// same-cycle implication, held off during reset
`define IP6MAC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define IP6MAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ip6mac_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ip6mac_pkg
// Shared constants, codes and controller/datapath types for the prefix table.
// ----------------------------------------------------------------------------
package ip6mac_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CFG_W   = 5;
  localparam int INDEX_W = 4;
  localparam int HALF_W  = 64;
  localparam int MAC_W   = 48;

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;
  localparam int REG_W   = PADDR_W - 2;

  // register indexes
  localparam logic [REG_W-1:0] REG_ENTRIES_IN_USE = 1'b0;

  // item opcodes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [HALF_W-1:0] prefix_hi;
    logic [HALF_W-1:0] prefix_lo;
    logic [HALF_W-1:0] mask_hi;
    logic [HALF_W-1:0] mask_lo;
    logic [MAC_W-1:0]  mac;
  } entry_t;

  typedef struct packed {
    logic              start;    // lookup accepted: latch key, clear best
    logic              load;     // load accepted: write entry
    logic              rd_en;    // read table at rd_addr
    logic [SLOT_W-1:0] rd_addr;
    logic              emit;     // move best match into output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;              // output register can take a word this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/ip6mac_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ip6mac_req_if
// Request channel: load or lookup words with valid/ready.
// ----------------------------------------------------------------------------
interface ip6mac_req_if import ip6mac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [INDEX_W-1:0] entry_index;
  logic [HALF_W-1:0]  addr_hi;
  logic [HALF_W-1:0]  addr_lo;
  logic [HALF_W-1:0]  mask_hi;
  logic [HALF_W-1:0]  mask_lo;
  logic [MAC_W-1:0]   entry_mac;

  modport source (
    output valid, cmd, entry_index, addr_hi, addr_lo, mask_hi, mask_lo, entry_mac,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, addr_hi, addr_lo, mask_hi, mask_lo, entry_mac,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/ip6mac_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ip6mac_rsp_if
// Response channel: lookup result words with valid/ready.
// ----------------------------------------------------------------------------
interface ip6mac_rsp_if import ip6mac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;

  modport source (output valid, hit, found_mac, input ready);
  modport sink (input valid, hit, found_mac, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ip6mac_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ip6mac_dp
// Entry memory, per-entry match/cover compare, best-match and output registers.
// ----------------------------------------------------------------------------
module ip6mac_dp import ip6mac_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [HALF_W-1:0]  addr_hi,
  input  wire logic [HALF_W-1:0]  addr_lo,
  input  wire logic [HALF_W-1:0]  mask_hi,
  input  wire logic [HALF_W-1:0]  mask_lo,
  input  wire logic [MAC_W-1:0]   entry_mac,
  input  wire logic               rsp_ready,
  output logic                    rsp_valid,
  output logic                    hit,
  output logic [MAC_W-1:0]        found_mac
);

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  logic              rd_valid;
  logic [HALF_W-1:0] key_hi;
  logic [HALF_W-1:0] key_lo;
  logic              found;
  logic [HALF_W-1:0] best_mask_hi;
  logic [HALF_W-1:0] best_mask_lo;
  logic [MAC_W-1:0]  best_mac;
  logic              wr_ok;
  logic              match;
  logic              covers;
  logic              take;

  // loads past the end of the table are dropped
  assign wr_ok = int'(entry_index) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem[SLOT_W'(entry_index)] <= '{prefix_hi: addr_hi, prefix_lo: addr_lo,
                                     mask_hi: mask_hi, mask_lo: mask_lo,
                                     mac: entry_mac};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  assign match  = ~|((key_hi ^ rd_data.prefix_hi) & rd_data.mask_hi) &&
                  ~|((key_lo ^ rd_data.prefix_lo) & rd_data.mask_lo);
  assign covers = ((rd_data.mask_hi & best_mask_hi) == best_mask_hi) &&
                  ((rd_data.mask_lo & best_mask_lo) == best_mask_lo);
  // later entry wins when its mask covers the current best
  assign take   = rd_valid && match && (!found || covers);

  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.start) begin
        found <= 1'b0;
      end else if (rd_valid && match) begin
        found <= 1'b1;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_hi <= addr_hi;
      key_lo <= addr_lo;
    end
    if (take) begin
      best_mask_hi <= rd_data.mask_hi;
      best_mask_lo <= rd_data.mask_lo;
      best_mac     <= rd_data.mac;
    end
    if (cmd.emit) begin
      hit       <= found;
      found_mac <= found ? best_mac : '0;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ip6mac_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ip6mac_ctrl
// Sequencer: takes request words, steps the table scan, hands off the result.
// ----------------------------------------------------------------------------
`include "ipv6_prefix_to_mac_table_macros.svh"

module ip6mac_ctrl import ip6mac_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic             req_cmd,
  output logic                  req_ready,
  input  wire logic [CNT_W-1:0] count_eff,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  logic              last;

  assign last = (int'(idx) + 1) == int'(count_eff);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    req_ready   = 1'b0;
    cmd         = '0;
    cmd.rd_addr = idx;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_cmd == CMD_LOOKUP) begin
            cmd.start  = 1'b1;
            idx_next   = '0;
            state_next = (count_eff == '0) ? ST_EMIT : ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (last) begin
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last read word is compared this cycle
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  `IP6MAC_ASSERT_IMPL(a_scan_in_range, clk, rst, state == ST_SCAN, int'(idx) < int'(count_eff), "scan index past entry count")
  `IP6MAC_ASSERT_NEXT(a_lookup_busy, clk, rst, req_valid && req_ready && req_cmd == CMD_LOOKUP, !req_ready, "lookup did not start a scan")
  `IP6MAC_ASSERT_NEXT(a_load_single, clk, rst, req_valid && req_ready && req_cmd == CMD_LOAD, req_ready, "load did not finish in one cycle")

endmodule
`default_nettype wire

/* hw/rtl/ipv6_prefix_to_mac_table.sv */
// Load word: no response; the next word may follow right away.
// Lookup word: N = min(entries_in_use, TABLE_DEPTH) entries read, one per cycle
// through the single table read port, then a drain state (neither when N is 0)
// and the emit state, which sets the response valid and returns to idle for the
// next word, but only while the output register is free or being read out.
// Reset: entries_in_use clears to 0; table contents stay undefined until loaded.
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_prefix_to_mac_table
// IPv6 prefix/mask to Ethernet address table with best-mask lookup.
// ----------------------------------------------------------------------------
module ipv6_prefix_to_mac_table import ip6mac_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // word channels
  ip6mac_req_if.sink              req,
  ip6mac_rsp_if.source            rsp
);

  logic [CFG_W-1:0] entries_in_use;
  logic [CNT_W-1:0] count_eff;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  // --------------------------------------------------------------------------
  // Configuration register. Zero-wait-state APB; writes land on the access
  // cycle. It must be written only while no lookup is in flight; not enforced.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE) begin
      entries_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_ENTRIES_IN_USE: prdata = PDATA_W'(entries_in_use);
      default:            prdata = '0;
    endcase
  end

  // counts above the table size scan the whole table
  assign count_eff = (int'(entries_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(entries_in_use);

  // --------------------------------------------------------------------------
  // Controller: accepts words in idle, walks slot 0..N-1, waits out the read
  // latency, then hands the result to the output register. The output register
  // in the datapath decouples the response side, so a new word can be taken
  // while the previous result is still waiting.
  // --------------------------------------------------------------------------
  ip6mac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .count_eff (count_eff),
    .stat      (stat),
    .cmd       (cmd)
  );

  // --------------------------------------------------------------------------
  // Datapath: entry memory (one write, one registered read), 128-bit masked
  // match and mask-cover compare per read word, best-so-far registers.
  // --------------------------------------------------------------------------
  ip6mac_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .entry_index (req.entry_index),
    .addr_hi     (req.addr_hi),
    .addr_lo     (req.addr_lo),
    .mask_hi     (req.mask_hi),
    .mask_lo     (req.mask_lo),
    .entry_mac   (req.entry_mac),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .hit         (rsp.hit),
    .found_mac   (rsp.found_mac)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv6 prefix to Ethernet address table. Loads and
// lookups go in through the request channel with random gaps. Every lookup
// result is checked against a typed-in result or a table model kept here. The
// run starts with directed rows and then random phases, each after a count write.
// ----------------------------------------------------------------------------
module tb_top;
  import ip6mac_pkg::*;

  // one request word as the bench sees it
  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] entry_index;
    logic [HALF_W-1:0]  addr_hi;
    logic [HALF_W-1:0]  addr_lo;
    logic [HALF_W-1:0]  mask_hi;
    logic [HALF_W-1:0]  mask_lo;
    logic [MAC_W-1:0]   entry_mac;
  } req_word_t;

  // one lookup result word
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
  } lookup_res_t;

  // directed row: optional scan count change, the word, and a typed-in
  // result where it is obvious by inspection
  typedef struct packed {
    logic             cfg_en;
    logic [CFG_W-1:0] cfg_v;
    req_word_t        w;
    logic             typed;
    lookup_res_t      res;
  } dir_row_t;

  localparam int SETTLE_CYCLES = 24;    // > longest lookup plus margin
  localparam int PHASE_WORDS   = 100;
  localparam int NUM_PHASES    = 12;
  localparam int HOLD_AT       = 150;   // result count that triggers the long hold
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ip6mac_req_if req_if ();
  ip6mac_rsp_if rsp_if ();

  ipv6_prefix_to_mac_table uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // table model: prefix, mask and address per slot, plus the scan count
  // --------------------------------------------------------------------------
  logic [2*HALF_W-1:0] pfx_tbl [TABLE_DEPTH];
  logic [2*HALF_W-1:0] msk_tbl [TABLE_DEPTH];
  logic [MAC_W-1:0]    mac_tbl [TABLE_DEPTH];
  bit                  loaded  [TABLE_DEPTH];
  logic [CFG_W-1:0]    scan_cnt;

  lookup_res_t pending_matches[$];      // lookup results still owed by the block
  dir_row_t    dir_rows[$];

  int mism_cnt = 0;
  int res_cnt  = 0;
  int calm_tx  = 0;
  int calm_rx  = 0;

  // append to the tail of the owed-result queue
  function automatic void owe_result(lookup_res_t r);
    pending_matches.insert(pending_matches.size(), r);
  endfunction

  // append a directed row
  function automatic void add_row(dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  // slots actually scanned: a count past the table scans the whole table
  function automatic int scan_span();
    return (scan_cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_cnt);
  endfunction

  // best-mask match over the scanned slots; equal masks go to the later slot,
  // incomparable masks keep the earlier best
  function automatic lookup_res_t best_entry_lookup(logic [2*HALF_W-1:0] a);
    lookup_res_t r;
    int          best;
    bit          found;
    best  = 0;
    found = 1'b0;
    for (int i = 0; i < scan_span(); i++) begin
      if (((a ^ pfx_tbl[i]) & msk_tbl[i]) == '0) begin
        if (!found || ((msk_tbl[i] & msk_tbl[best]) == msk_tbl[best]))
          best = i;
        found = 1'b1;
      end
    end
    r.hit = found;
    r.mac = found ? mac_tbl[best] : '0;
    return r;
  endfunction

  // gap length: mostly none or short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 880) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [2*HALF_W-1:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // random load: prefix-length masks mostly, some raw masks and the extremes;
  // prefixes often nest under an existing entry so masks overlap
  function automatic req_word_t rand_load(int slot);
    req_word_t           w;
    logic [2*HALF_W-1:0] p;
    logic [2*HALF_W-1:0] m;
    int                  r;
    int                  s;
    w = {1'b0, 4'(slot), rand128(), rand128(), 48'({$urandom, $urandom})};
    w.cmd = CMD_LOAD;
    r = $urandom_range(0, 99);
    if (r < 8)       m = '0;
    else if (r < 18) m = '1;
    else if (r < 33) m = rand128();
    else             m = ~({(2*HALF_W){1'b1}} >> $urandom_range(1, 127));
    p = rand128();
    s = $urandom_range(0, TABLE_DEPTH - 1);
    if ($urandom_range(0, 99) < 60 && loaded[s])
      p = (pfx_tbl[s] & msk_tbl[s]) | (p & ~msk_tbl[s]);
    {w.addr_hi, w.addr_lo} = p;
    {w.mask_hi, w.mask_lo} = m;
    return w;
  endfunction

  // random word: loads anywhere, lookups mostly aimed inside a scanned entry
  function automatic req_word_t gen_word();
    req_word_t           w;
    logic [2*HALF_W-1:0] a;
    int                  n;
    int                  s;
    int                  r;
    n = scan_span();
    if ($urandom_range(0, 99) < 30)
      return rand_load($urandom_range(0, TABLE_DEPTH - 1));
    w = {1'b1, 4'($urandom), rand128(), rand128(), 48'({$urandom, $urandom})};
    w.cmd = CMD_LOOKUP;
    a = rand128();
    r = $urandom_range(0, 99);
    if (n > 0 && r < 75) begin
      s = $urandom_range(0, n - 1);
      a = (pfx_tbl[s] & msk_tbl[s]) | (a & ~msk_tbl[s]);
    end else if (r > 95) begin
      a = (r[0]) ? '1 : '0;
    end
    {w.addr_hi, w.addr_lo} = a;
    return w;
  endfunction

  function automatic void add_load(logic [INDEX_W-1:0] idx, logic [HALF_W-1:0] ahi,
                                   logic [HALF_W-1:0] alo, logic [HALF_W-1:0] mhi,
                                   logic [HALF_W-1:0] mlo, logic [MAC_W-1:0] mac);
    dir_row_t d;
    d = '0;
    d.w = {CMD_LOAD, idx, ahi, alo, mhi, mlo, mac};
    add_row(d);
  endfunction

  // lookup rows carry all-ones in the fields a lookup ignores
  function automatic void add_lookup(logic cfg_en, logic [CFG_W-1:0] cfg_v,
                                     logic [HALF_W-1:0] ahi, logic [HALF_W-1:0] alo,
                                     logic typed, logic ehit, logic [MAC_W-1:0] emac);
    dir_row_t d;
    d = '0;
    d.cfg_en = cfg_en;
    d.cfg_v  = cfg_v;
    d.w      = {CMD_LOOKUP, 4'hF, ahi, alo, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
    d.typed  = typed;
    d.res    = {ehit, emac};
    add_row(d);
  endfunction

  // --------------------------------------------------------------------------
  // request side: gap, offer, wait for the handshake, then update the model.
  // valid is only lowered ahead of a real gap, never dropped and raised in
  // the same step.
  // --------------------------------------------------------------------------
  task automatic send_word(req_word_t w, logic typed, lookup_res_t tres);
    int g;
    g = pick_gap(calm_tx);
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= w.cmd;
    req_if.entry_index <= w.entry_index;
    req_if.addr_hi     <= w.addr_hi;
    req_if.addr_lo     <= w.addr_lo;
    req_if.mask_hi     <= w.mask_hi;
    req_if.mask_lo     <= w.mask_lo;
    req_if.entry_mac   <= w.entry_mac;
    do @(posedge clk); while (!req_if.ready);
    if (w.cmd == CMD_LOAD) begin
      pfx_tbl[w.entry_index] = {w.addr_hi, w.addr_lo};
      msk_tbl[w.entry_index] = {w.mask_hi, w.mask_lo};
      mac_tbl[w.entry_index] = w.entry_mac;
      loaded[w.entry_index]  = 1'b1;
    end else if (typed) begin
      owe_result(tres);
    end else begin
      owe_result(best_entry_lookup({w.addr_hi, w.addr_lo}));
    end
  endtask

  // stop offering, wait for every owed result, then let a trailing load finish
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the scan count; junk in the upper data bits must be dropped
  task automatic write_scan_cnt(logic [CFG_W-1:0] cnt);
    logic [PDATA_W-1:0] v;
    v = $urandom;
    v[CFG_W-1:0] = cnt;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    scan_cnt = v[CFG_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // response side: check each result word, drive ready with random gaps and
  // one long hold so the block backs up into the request channel
  // --------------------------------------------------------------------------
  lookup_res_t rx_exp;
  int          rx_gap    = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        res_cnt++;
        if (pending_matches.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("unexpected result word: hit=%0b mac=%012h",
                     rsp_if.hit, rsp_if.found_mac);
        end else begin
          rx_exp = pending_matches.pop_front();
          if (rsp_if.hit !== rx_exp.hit || rsp_if.found_mac !== rx_exp.mac) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("result %0d mismatch: exp hit=%0b mac=%012h, got hit=%0b mac=%012h",
                       res_cnt, rx_exp.hit, rx_exp.mac, rsp_if.hit, rsp_if.found_mac);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && res_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        rx_gap = pick_gap(calm_rx);
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int phase_cnts [NUM_PHASES] = '{16, 31, 0, 1, 17, 16, 2, 24, 9, 31, 16, 5};

  initial begin
    lookup_res_t none;
    int          n;
    none     = '0;
    scan_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pfx_tbl[i] = '0;
      msk_tbl[i] = '0;
      mac_tbl[i] = '0;
      loaded[i]  = 1'b0;
    end
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_if.valid       <= 1'b0;
    req_if.cmd         <= CMD_LOAD;
    req_if.entry_index <= '0;
    req_if.addr_hi     <= '0;
    req_if.addr_lo     <= '0;
    req_if.mask_hi     <= '0;
    req_if.mask_lo     <= '0;
    req_if.entry_mac   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    // count 0 after reset: nothing scanned, so a miss
    add_lookup(1'b0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               1'b1, 1'b0, 48'h0);
    // slot 0: default route, empty mask matches all, zero address
    add_load(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 48'h0);
    // slot 1: all-ones host route, all-ones address
    add_load(4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    // slot 2: all-zero host route
    add_load(4'd2, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             48'h0000_0000_0002);
    // slots 3 and 5 share a /32, so the later one wins on equal masks
    add_load(4'd3, 64'h2001_0DB8_0000_0000, 64'h0, 64'hFFFF_FFFF_0000_0000, 64'h0,
             48'h0200_0000_0003);
    add_load(4'd4, 64'h2001_0DB8_0001_0000, 64'h0, 64'hFFFF_FFFF_FFFF_0000, 64'h0,
             48'h0200_0000_0004);
    add_load(4'd5, 64'h2001_0DB8_0000_0000, 64'h0, 64'hFFFF_FFFF_0000_0000, 64'h0,
             48'h0200_0000_0005);
    // slot 6: mask that neither covers nor is covered by slot 4
    add_load(4'd6, 64'h0000_0000_0001_0000, 64'h0000_0000_0000_0001,
             64'h0000_0000_FFFF_0000, 64'h0000_0000_0000_00FF, 48'h0200_0000_0006);
    // slot 15: link-local /10 in the top slot
    add_load(4'd15, 64'hFE80_0000_0000_0000, 64'h0, 64'hFFC0_0000_0000_0000, 64'h0,
             48'hAAAA_AAAA_AAAA);
    // count 1: only the default route, hit with a zero address
    add_lookup(1'b1, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               1'b1, 1'b1, 48'h0);
    add_lookup(1'b0, 5'd0, 64'h0, 64'h0, 1'b1, 1'b1, 48'h0);
    // count 2: the host route covers the empty mask
    add_lookup(1'b1, 5'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
    add_lookup(1'b0, 5'd0, 64'h0, 64'h0, 1'b1, 1'b1, 48'h0);
    // count 7: overlap cases, checked by the model
    add_lookup(1'b1, 5'd7, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0);
    add_lookup(1'b0, 5'd0, 64'h2001_0DB8_0000_0000, 64'h0000_0000_0000_0001,
               1'b0, 1'b0, 48'h0);
    add_lookup(1'b0, 5'd0, 64'h2001_0DB8_0001_0000, 64'h0000_0000_0000_0001,
               1'b0, 1'b0, 48'h0);
    add_lookup(1'b0, 5'd0, 64'h2001_0DB8_0001_0000, 64'h0000_0000_0000_0002,
               1'b0, 1'b0, 48'h0);
    add_lookup(1'b0, 5'd0, 64'h2001_0DB8_0002_0000, 64'hFFFF_FFFF_FFFF_FFFF,
               1'b0, 1'b0, 48'h0);
    add_lookup(1'b0, 5'd0, 64'hFE80_0000_0000_0000, 64'h1234_5678_9ABC_DEF0,
               1'b0, 1'b0, 48'h0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_en) begin
        settle();
        write_scan_cnt(dir_rows[i].cfg_v);
      end
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases; count list hits 0, 1, 16 and the 5-bit top first
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_scan_cnt(5'(phase_cnts[ph]));
      // every scanned slot must hold a loaded entry before a lookup
      n = scan_span();
      for (int s = 0; s < n; s++)
        if (!loaded[s]) send_word(rand_load(s), 1'b0, none);
      repeat (PHASE_WORDS) send_word(gen_word(), 1'b0, none);
    end

    settle();
    if (mism_cnt == 0 && pending_matches.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
